// File: rtl/sfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared constants and types for the symmetric 11-tap FIR filter.
// ----------------------------------------------------------------------------
package sfir_pkg;

  localparam int TAPS            = 11;
  localparam int DEPTH           = TAPS - 1;
  localparam int MID_TAP         = (TAPS - 1) / 2;
  localparam int NUM_COEF        = MID_TAP + 1;
  localparam int COEF_W          = 16;
  localparam int OUT_W           = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int SAMPLE_BITS_DEF = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_END   = 3'd0,
    CFG_COEF_ONE   = 3'd1,
    CFG_COEF_TWO   = 3'd2,
    CFG_COEF_THREE = 3'd3,
    CFG_COEF_FOUR  = 3'd4,
    CFG_COEF_MID   = 3'd5
  } cfg_idx_e;

  // Low-pass design rounded to Q1.15
  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    16'sd0, 16'sd621, 16'sd2256, 16'sd4287, 16'sd5937, 16'sd6568
  };

endpackage

// File: rtl/sfir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_if
// Handshake channels of the FIR filter: sample input, result output and
// coefficient write port.
// ----------------------------------------------------------------------------
interface sfir_in_if #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface sfir_out_if;
  import sfir_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

interface sfir_cfg_if;
  import sfir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/sfir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfir_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 10,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/symmetric_fir_11tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_11tap
// Symmetric 11-tap FIR filter with one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Each accepted sample is filtered with the ten stored samples in a circular
// RAM. One multiplier walks the eleven taps, one per cycle, and the result is
// registered before the next sample is taken: one sample is filtered at a
// time, since the single RAM read port and the shared multiplier serve every
// tap. The finished result sits in an output register, so the next sample is
// accepted while it waits to be taken. Coefficient writes are always taken;
// writes to indexes past the center tap are dropped. The delay line reads as
// zero after reset without a clearing pass.
module symmetric_fir_11tap #(
  parameter int SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfir_in_if.sink   in_i,
  sfir_out_if.source out_o,
  sfir_cfg_if.sink  cfg_i
);
  import sfir_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(TAPS);
  localparam int PROD_W = COEF_W + SAMPLE_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic signed [COEF_W-1:0] coef_q [NUM_COEF];
  logic [DEPTH-1:0]         valid_q;
  logic [ADDR_W-1:0]        head_q, rd_addr_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     issue_q;
  logic [SAMPLE_BITS-1:0]   sample_q;

  logic                     s1_v_q, s1_hit_q;
  logic [CNT_W-1:0]         s1_tap_q;
  logic                     prod_v_q, prod_last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [OUT_W-1:0]  acc_q;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  filtered_q;

  logic                     in_fire, rd_en, out_free, finish;
  logic [ADDR_W-1:0]        wr_addr, rd_addr_dec;
  logic [SAMPLE_BITS-1:0]   ram_rdata, operand;
  logic [CNT_W-1:0]         mirror, coef_idx;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0] prod_d;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_free = !out_valid_q || out_o.ready;
  assign finish   = (state_q == ST_DONE) && out_free;
  assign rd_en    = issue_q && (cnt_q != '0);

  assign wr_addr     = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);
  assign rd_addr_dec = (rd_addr_q == '0) ? ADDR_W'(DEPTH - 1) : rd_addr_q - ADDR_W'(1);

  sfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (finish),
    .waddr_i (wr_addr),
    .wdata_i (sample_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr_q),
    .rdata_o (ram_rdata)
  );

  // Taps k and TAPS-1-k share one coefficient
  always_comb begin
    mirror   = CNT_W'(TAPS - 1) - s1_tap_q;
    coef_idx = (s1_tap_q <= CNT_W'(MID_TAP)) ? s1_tap_q : mirror;
    coef_sel = coef_q[coef_idx[CFG_IDX_W-1:0]];
    if (s1_tap_q == '0) begin
      operand = sample_q;
    end else if (s1_hit_q) begin
      operand = ram_rdata;
    end else begin
      operand = '0;
    end
    prod_d = PROD_W'(coef_sel * $signed({1'b0, operand}));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (prod_v_q && prod_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      head_q      <= '0;
      cnt_q       <= '0;
      issue_q     <= 1'b0;
      s1_v_q      <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && (cfg_i.index <= CFG_IDX_W'(CFG_COEF_MID))) begin
        coef_q[cfg_i.index] <= $signed(cfg_i.data);
      end

      // Walk the taps: tap 0 from the held sample, the rest from RAM
      if (in_fire) begin
        issue_q <= 1'b1;
        cnt_q   <= '0;
      end else if (issue_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TAPS - 1)) begin
          issue_q <= 1'b0;
        end
      end

      s1_v_q      <= issue_q;
      prod_v_q    <= s1_v_q;
      prod_last_q <= s1_v_q && (s1_tap_q == CNT_W'(TAPS - 1));

      if (finish) begin
        valid_q[wr_addr] <= 1'b1;
        head_q           <= wr_addr;
        out_valid_q      <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q  <= in_i.sample;
      rd_addr_q <= head_q;
    end else if (rd_en) begin
      rd_addr_q <= rd_addr_dec;
    end

    s1_tap_q <= cnt_q;
    s1_hit_q <= valid_q[rd_addr_q];
    prod_q   <= prod_d;

    if (in_fire) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + OUT_W'(prod_q);
    end

    if (finish) begin
      filtered_q <= acc_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = filtered_q;

endmodule
